@@ hdl/pgsf_pkg.sv @@
// ----------------------------------------------------------------------------
// pgsf_pkg
// Shared constants and controller/datapath interface types for the
// polygon scanline span fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pgsf_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 12;
  localparam int MaxResults  = 8;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int ResBits     = $clog2(MaxResults + 1);
  localparam int ErrBits     = 16;
  localparam int CfgIdxBits  = 3;

  localparam logic [CfgIdxBits-1:0] CfgClipEnable = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgClipLeft   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgClipTop    = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgClipWidth  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgClipHeight = 3'd4;

  localparam logic [1:0] EsUnused   = 2'd0;
  localparam logic [1:0] EsWaiting  = 2'd1;
  localparam logic [1:0] EsActive   = 2'd2;
  localparam logic [1:0] EsFinished = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic vtx_load;
    logic row_start;
    logic idle_out;
    logic close_step;
    logic scan_edge;
    logic adv_step;
    logic adv_done;
    logic emit_pair;
    logic row_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic filling;
    logic close_end;
    logic edge_live;
    logic k_last;
    logic adv_loop;
    logic pair_avail;
    logic span_hold;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/pgsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgsf_ctrl
// Sequencer for vertex loading, polygon closing and the per-row edge scan,
// Bresenham advance and span emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          operation_i,
  input  wire logic          last_vertex_i,
  input  wire pgsf_pkg::sts_t sts_i,
  output pgsf_pkg::cmd_t     cmd_o
);
  import pgsf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLOSE = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_ADV   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_FINAL = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!operation_i) begin
            cmd_o.vtx_load = 1'b1;
            if (last_vertex_i) state_d = ST_CLOSE;
          end else if (!sts_i.filling) begin
            cmd_o.idle_out = 1'b1;
          end else begin
            cmd_o.row_start = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLOSE: begin
        cmd_o.close_step = 1'b1;
        if (sts_i.close_end) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_edge = 1'b1;
        if (sts_i.edge_live) state_d = ST_ADV;
        else if (sts_i.k_last) state_d = ST_EMIT;
      end
      ST_ADV: begin
        if (sts_i.adv_loop) begin
          cmd_o.adv_step = 1'b1;
        end else begin
          cmd_o.adv_done = 1'b1;
          state_d = sts_i.k_last ? ST_EMIT : ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (!sts_i.pair_avail) state_d = ST_FINAL;
        else if (!sts_i.span_hold) cmd_o.emit_pair = 1'b1;
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.row_end = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd_o))
    else $error("more than one datapath command");
  a_adv_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADV |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_ADV))
    else $error("advance entered without scan");
  a_scan_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> sts_i.filling)
    else $error("row scan outside fill mode");

endmodule

`default_nettype wire

@@ hdl/pgsf_datapath.sv @@
// ----------------------------------------------------------------------------
// pgsf_datapath
// Vertex store, edge records, sorted active column list, Bresenham stepper,
// span clipping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsf_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pgsf_pkg::cmd_t                      cmd_i,
  output pgsf_pkg::sts_t                           sts_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [pgsf_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  wire logic [pgsf_pkg::CoordBits-1:0]      cfg_data_i,
  input  wire logic signed [pgsf_pkg::CoordBits-1:0] vertex_x_i,
  input  wire logic signed [pgsf_pkg::CoordBits-1:0] vertex_y_i,
  input  wire logic                                last_vertex_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [pgsf_pkg::CoordBits-1:0]    span_row_o,
  output logic signed [pgsf_pkg::CoordBits-1:0]    span_start_o,
  output logic signed [pgsf_pkg::CoordBits-1:0]    span_end_o,
  output logic                                     span_valid_o,
  output logic                                     last_of_row_o,
  output logic                                     polygon_done_o
);
  import pgsf_pkg::*;

  localparam int Cb = CoordBits;

  // configuration
  logic         clip_en_q;
  coord_t       clip_left_q, clip_top_q;
  logic [Cb-1:0] clip_w_q, clip_h_q;

  // vertex store
  coord_t vcol_q [MaxVertices];
  coord_t vrow_q [MaxVertices];
  logic [CntBits-1:0] vcount_q;

  // edge records
  coord_t e_start_q [MaxVertices];
  coord_t e_end_q   [MaxVertices];
  coord_t e_col_q   [MaxVertices];
  logic [Cb:0] e_tdx_q [MaxVertices];
  logic [Cb:0] e_tdy_q [MaxVertices];
  logic        e_left_q [MaxVertices];
  logic signed [ErrBits-1:0] e_err_q [MaxVertices];
  logic [1:0]  e_state_q [MaxVertices];

  coord_t cur_row_q, low_q, high_q;
  logic   filling_q;

  // close walk
  logic [CntBits-1:0] ci_q;
  coord_t first_col_q, first_row_q, prev_col_q, prev_row_q;

  // row walk
  logic [IdxBits-1:0] k_q;
  coord_t wx_q;
  logic signed [ErrBits-1:0] wf_q;
  logic [Cb:0] wtdx_q, wtdy_q;
  logic wleft_q;
  coord_t cols_q [MaxVertices];
  logic [CntBits-1:0] nact_q;
  logic [ResBits-1:0] nres_q;
  logic   pend_q;
  coord_t pa_q, pb_q;

  // output register
  logic   out_valid_q;
  coord_t o_row_q, o_start_q, o_end_q;
  logic   o_sv_q, o_last_q, o_done_q;

  // ---------------- close: edge builder ----------------
  coord_t cv_col, cv_row, ea_col, ea_row, eb_col, eb_row;
  coord_t b_start, b_end, b_col;
  logic signed [Cb:0] b_dx, b_dy;
  logic [Cb:0] b_adx;
  logic signed [Cb+1:0] b_err;
  logic b_horiz, close_end;
  logic [IdxBits-1:0] widx;

  assign cv_col    = vcol_q[ci_q[IdxBits-1:0]];
  assign cv_row    = vrow_q[ci_q[IdxBits-1:0]];
  assign close_end = (ci_q == vcount_q);
  assign ea_col    = prev_col_q;
  assign ea_row    = prev_row_q;
  assign eb_col    = close_end ? first_col_q : cv_col;
  assign eb_row    = close_end ? first_row_q : cv_row;
  assign widx      = IdxBits'(ci_q - CntBits'(1));

  always_comb begin
    b_horiz = (ea_row == eb_row);
    if (ea_row < eb_row) begin
      b_start = ea_row;
      b_end   = eb_row;
      b_col   = ea_col;
      b_dx    = {eb_col[Cb-1], eb_col} - {ea_col[Cb-1], ea_col};
      b_dy    = {eb_row[Cb-1], eb_row} - {ea_row[Cb-1], ea_row};
    end else begin
      b_start = eb_row;
      b_end   = ea_row;
      b_col   = eb_col;
      b_dx    = {ea_col[Cb-1], ea_col} - {eb_col[Cb-1], eb_col};
      b_dy    = {ea_row[Cb-1], ea_row} - {eb_row[Cb-1], eb_row};
    end
    b_adx = b_dx[Cb] ? (Cb+1)'(-b_dx) : b_dx;
    if ($signed({1'b0, b_adx}) > $signed({b_dy[Cb], b_dy})) begin
      b_err = $signed({b_dy[Cb], b_dy}) - $signed({1'b0, b_adx});
    end else begin
      b_err = $signed({1'b0, b_adx}) - $signed({b_dy[Cb], b_dy});
    end
  end

  // ---------------- scan: state update and sorted insert ----------------
  logic [1:0] s_old, s_new;
  coord_t     s_col;
  logic       s_live;
  logic [MaxVertices-1:0] le;
  coord_t     ins_cols [MaxVertices];

  assign s_old = e_state_q[k_q];
  assign s_col = e_col_q[k_q];

  always_comb begin
    s_new = s_old;
    if (s_new == EsWaiting && e_start_q[k_q] == cur_row_q) s_new = EsActive;
    if (s_new == EsActive && e_end_q[k_q] == cur_row_q) s_new = EsFinished;
    s_live = (s_new == EsActive);
  end

  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      le[i] = (CntBits'(i) < nact_q) && (cols_q[i] <= s_col);
    end
    for (int i = 0; i < MaxVertices; i++) begin
      if (le[i]) ins_cols[i] = cols_q[i];
      else if (i == 0) ins_cols[i] = s_col;
      else if (le[i-1]) ins_cols[i] = s_col;
      else ins_cols[i] = cols_q[i-1];
    end
  end

  // ---------------- Bresenham step ----------------
  coord_t step_x, fin_x;
  logic signed [ErrBits-1:0] fin_f, tdx_s, tdy_s;
  logic steep_x, adv_loop;

  assign step_x  = wleft_q ? wx_q - Cb'(1) : wx_q + Cb'(1);
  assign tdx_s   = ErrBits'(wtdx_q);
  assign tdy_s   = ErrBits'(wtdy_q);
  assign steep_x = wtdx_q > wtdy_q;
  assign adv_loop = steep_x && wf_q[ErrBits-1] && (wtdy_q != '0);

  always_comb begin
    fin_x = wx_q;
    if (steep_x) begin
      fin_f = wf_q - tdx_s;
    end else if (!wf_q[ErrBits-1]) begin
      fin_x = step_x;
      fin_f = wf_q - tdy_s + tdx_s;
    end else begin
      fin_f = wf_q + tdx_s;
    end
  end

  // ---------------- span clip ----------------
  logic signed [Cb+1:0] r_w, top_w, bot_w, left_w, right_w, a_w, b_w, ca, cb;
  logic row_in, span_ok, done_row, out_free, out_load;
  coord_t ld_row, ld_start, ld_end;
  logic ld_sv, ld_last, ld_done;

  always_comb begin
    r_w     = (Cb+2)'(cur_row_q);
    top_w   = (Cb+2)'(clip_top_q);
    bot_w   = top_w + $signed({2'b00, clip_h_q});
    left_w  = (Cb+2)'(clip_left_q);
    right_w = left_w + $signed({2'b00, clip_w_q}) - (Cb+2)'(1);
    a_w     = (Cb+2)'(cols_q[0]);
    b_w     = (Cb+2)'(cols_q[1]);
    ca      = a_w;
    cb      = b_w;
    row_in  = 1'b1;
    if (clip_en_q) begin
      row_in = (r_w >= top_w) && (r_w < bot_w);
      if (a_w < left_w) ca = left_w;
      if (b_w > right_w) cb = right_w;
    end
    span_ok = row_in && (ca <= cb);
  end

  assign done_row = (cur_row_q >= high_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_load = 1'b0;
    ld_row   = '0;
    ld_start = '0;
    ld_end   = '0;
    ld_sv    = 1'b0;
    ld_last  = 1'b0;
    ld_done  = 1'b0;
    if (cmd_i.idle_out) begin
      out_load = 1'b1;
      ld_last  = 1'b1;
      ld_done  = 1'b1;
    end else if (cmd_i.emit_pair && span_ok && pend_q) begin
      out_load = 1'b1;
      ld_row   = cur_row_q;
      ld_start = pa_q;
      ld_end   = pb_q;
      ld_sv    = 1'b1;
    end else if (cmd_i.row_end) begin
      out_load = 1'b1;
      ld_row   = cur_row_q;
      ld_last  = 1'b1;
      ld_done  = done_row;
      if (pend_q) begin
        ld_start = pa_q;
        ld_end   = pb_q;
        ld_sv    = 1'b1;
      end
    end
  end

  // ---------------- status ----------------
  assign sts_o.out_free   = out_free;
  assign sts_o.filling    = filling_q;
  assign sts_o.close_end  = close_end;
  assign sts_o.edge_live  = s_live;
  assign sts_o.k_last     = (k_q == IdxBits'(MaxVertices - 1));
  assign sts_o.adv_loop   = adv_loop;
  assign sts_o.pair_avail = (nact_q >= CntBits'(2)) && (nres_q < ResBits'(MaxResults));
  assign sts_o.span_hold  = span_ok && pend_q && !out_free;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_en_q   <= 1'b0;
      clip_left_q <= '0;
      clip_top_q  <= '0;
      clip_w_q    <= '0;
      clip_h_q    <= '0;
      vcount_q    <= '0;
      cur_row_q   <= '0;
      low_q       <= '0;
      high_q      <= '0;
      filling_q   <= 1'b0;
      ci_q        <= '0;
      k_q         <= '0;
      nact_q      <= '0;
      nres_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) e_state_q[i] <= EsUnused;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgClipEnable: clip_en_q   <= cfg_data_i[0];
          CfgClipLeft:   clip_left_q <= cfg_data_i;
          CfgClipTop:    clip_top_q  <= cfg_data_i;
          CfgClipWidth:  clip_w_q    <= cfg_data_i;
          CfgClipHeight: clip_h_q    <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (cmd_i.vtx_load) begin
        if (filling_q) begin
          filling_q <= 1'b0;
          vcount_q  <= CntBits'(1);
        end else if (vcount_q < CntBits'(MaxVertices)) begin
          vcount_q  <= vcount_q + CntBits'(1);
        end
        if (filling_q || last_vertex_i) begin
          for (int i = 0; i < MaxVertices; i++) e_state_q[i] <= EsUnused;
        end
        ci_q <= '0;
      end

      if (cmd_i.close_step) begin
        if (!close_end) begin
          ci_q <= ci_q + CntBits'(1);
          if (ci_q == '0) begin
            low_q  <= cv_row;
            high_q <= cv_row;
          end else begin
            if (cv_row < low_q) low_q <= cv_row;
            if (cv_row > high_q) high_q <= cv_row;
            if (!b_horiz) e_state_q[widx] <= EsWaiting;
          end
        end else begin
          filling_q <= 1'b1;
          vcount_q  <= '0;
          if (vcount_q == '0) begin
            low_q     <= '0;
            high_q    <= '0;
            cur_row_q <= '0;
          end else begin
            cur_row_q <= low_q;
            if (!b_horiz) e_state_q[widx] <= EsWaiting;
          end
        end
      end

      if (cmd_i.row_start) begin
        k_q    <= '0;
        nact_q <= '0;
        nres_q <= '0;
        pend_q <= 1'b0;
      end

      if (cmd_i.scan_edge) begin
        e_state_q[k_q] <= s_new;
        if (s_live) nact_q <= nact_q + CntBits'(1);
        else k_q <= k_q + IdxBits'(1);
      end

      if (cmd_i.adv_done) k_q <= k_q + IdxBits'(1);

      if (cmd_i.emit_pair) begin
        nact_q <= nact_q - CntBits'(2);
        if (span_ok) begin
          pend_q <= 1'b1;
          nres_q <= nres_q + ResBits'(1);
        end
      end

      if (cmd_i.row_end) begin
        if (done_row) begin
          filling_q <= 1'b0;
          vcount_q  <= '0;
          for (int i = 0; i < MaxVertices; i++) e_state_q[i] <= EsUnused;
        end else begin
          cur_row_q <= cur_row_q + Cb'(1);
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_load) begin
      if (filling_q) begin
        vcol_q[0] <= vertex_x_i;
        vrow_q[0] <= vertex_y_i;
      end else if (vcount_q < CntBits'(MaxVertices)) begin
        vcol_q[vcount_q[IdxBits-1:0]] <= vertex_x_i;
        vrow_q[vcount_q[IdxBits-1:0]] <= vertex_y_i;
      end
    end

    if (cmd_i.close_step && !close_end) begin
      prev_col_q <= cv_col;
      prev_row_q <= cv_row;
      if (ci_q == '0) begin
        first_col_q <= cv_col;
        first_row_q <= cv_row;
      end
    end

    if (cmd_i.close_step && (!close_end || vcount_q != '0) && ci_q != '0 && !b_horiz) begin
      e_start_q[widx] <= b_start;
      e_end_q[widx]   <= b_end;
      e_col_q[widx]   <= b_col;
      e_left_q[widx]  <= b_dx[Cb];
      e_tdx_q[widx]   <= {b_adx[Cb-1:0], 1'b0};
      e_tdy_q[widx]   <= {b_dy[Cb-1:0], 1'b0};
      e_err_q[widx]   <= ErrBits'(b_err);
    end

    if (cmd_i.scan_edge && s_live) begin
      for (int i = 0; i < MaxVertices; i++) cols_q[i] <= ins_cols[i];
      wx_q    <= s_col;
      wf_q    <= e_err_q[k_q];
      wtdx_q  <= e_tdx_q[k_q];
      wtdy_q  <= e_tdy_q[k_q];
      wleft_q <= e_left_q[k_q];
    end

    if (cmd_i.adv_step) begin
      wx_q <= step_x;
      wf_q <= wf_q + tdy_s;
    end

    if (cmd_i.adv_done) begin
      e_col_q[k_q] <= fin_x;
      e_err_q[k_q] <= fin_f;
    end

    if (cmd_i.emit_pair) begin
      for (int i = 0; i < MaxVertices - 2; i++) cols_q[i] <= cols_q[i+2];
      if (span_ok) begin
        pa_q <= Cb'(ca);
        pb_q <= Cb'(cb);
      end
    end

    if (out_load) begin
      o_row_q   <= ld_row;
      o_start_q <= ld_start;
      o_end_q   <= ld_end;
      o_sv_q    <= ld_sv;
      o_last_q  <= ld_last;
      o_done_q  <= ld_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_row_o     = o_row_q;
  assign span_start_o   = o_start_q;
  assign span_end_o     = o_end_q;
  assign span_valid_o   = o_sv_q;
  assign last_of_row_o  = o_last_q;
  assign polygon_done_o = o_done_q;

endmodule

`default_nettype wire

@@ hdl/polygon_scanline_span_fill_unit.sv @@
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_unit
// Scanline polygon filler: loads vertices, builds Bresenham edge records and
// emits clipped inclusive spans one row step at a time.
// ----------------------------------------------------------------------------
// A vertex item needs only its acceptance; the vertex that closes the polygon
// adds a closing walk over the stored vertices. A row step is accepted, scans
// the edge slots, updates each active edge by Bresenham (stepping column by
// column in a loop for shallow edges, with no loop for steep ones), emits the
// column pairs in turn, finishes the row and waits while the output is held;
// it gives one to eight result items through a registered output.
`default_nettype none

module polygon_scanline_span_fill_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  operation_i,
  input  wire logic signed [pgsf_pkg::CoordBits-1:0] vertex_x_i,
  input  wire logic signed [pgsf_pkg::CoordBits-1:0] vertex_y_i,
  input  wire logic                                  last_vertex_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [pgsf_pkg::CoordBits-1:0]      span_row_o,
  output logic signed [pgsf_pkg::CoordBits-1:0]      span_start_o,
  output logic signed [pgsf_pkg::CoordBits-1:0]      span_end_o,
  output logic                                       span_valid_o,
  output logic                                       last_of_row_o,
  output logic                                       polygon_done_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [pgsf_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  wire logic [pgsf_pkg::CoordBits-1:0]        cfg_data_i
);
  import pgsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pgsf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .last_vertex_i (last_vertex_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pgsf_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .span_row_o     (span_row_o),
    .span_start_o   (span_start_o),
    .span_end_o     (span_end_o),
    .span_valid_o   (span_valid_o),
    .last_of_row_o  (last_of_row_o),
    .polygon_done_o (polygon_done_o)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polygon scanline span fill unit. Directed rows
// cover reset, square/degenerate/extreme polygons and fill abandon; random
// polygons follow under several clip windows, with idle bursts, one long
// output stall, and every span compared against an in-bench row predictor.
// ----------------------------------------------------------------------------
module tb;
  import pgsf_pkg::*;

  localparam int StallLimit = 400000;

  typedef struct {
    logic signed [CoordBits-1:0] row;
    logic signed [CoordBits-1:0] first_col;
    logic signed [CoordBits-1:0] last_col;
    bit                          has_span;
    bit                          row_last;
    bit                          poly_done;
  } span_t;

  typedef struct {
    bit    op;
    int    x;
    int    y;
    bit    lastv;
    bit    typed;
    span_t exp;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op_in = 1'b0;
  logic signed [CoordBits-1:0] vx_in = '0;
  logic signed [CoordBits-1:0] vy_in = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CoordBits-1:0] row_out, start_out, end_out;
  logic sv_out, lor_out, done_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CoordBits-1:0] cfg_data = '0;

  polygon_scanline_span_fill_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op_in), .vertex_x_i(vx_in), .vertex_y_i(vy_in),
    .last_vertex_i(last_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .span_row_o(row_out), .span_start_o(start_out), .span_end_o(end_out),
    .span_valid_o(sv_out), .last_of_row_o(lor_out), .polygon_done_o(done_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit        clip_en;
  int        clip_l, clip_t, clip_w, clip_h;
  int        vtx_col[MaxVertices];
  int        vtx_row[MaxVertices];
  int        vtx_cnt;
  int        e_start[MaxVertices];
  int        e_end[MaxVertices];
  int        e_col[MaxVertices];
  int        e_tdx[MaxVertices];
  int        e_tdy[MaxVertices];
  bit        e_left[MaxVertices];
  int        e_err[MaxVertices];
  logic [1:0] e_state[MaxVertices];
  int        cur_row, low_row, high_row;
  bit        filling;

  span_t span_q[$];
  step_t plan[$];

  int  n_items, n_rows, n_spans, n_polys, n_cfg, n_fail, idle_cycles;
  bit  quiet, stall_req;
  int  hold_left, burst_left;

  function automatic int wrap_col(int v);
    logic signed [CoordBits-1:0] w;
    w = v[CoordBits-1:0];
    return int'(w);
  endfunction

  function automatic void close_poly();
    int j, ys, ye, xs, xe, dx, dy;
    for (int k = 0; k < MaxVertices; k++) e_state[k] = EsUnused;
    low_row = 0;
    high_row = 0;
    if (vtx_cnt > 0) begin
      low_row = vtx_row[0];
      high_row = vtx_row[0];
    end
    for (int k = 0; k < vtx_cnt; k++) begin
      j = (k + 1 < vtx_cnt) ? k + 1 : 0;
      ys = vtx_row[k]; ye = vtx_row[j];
      xs = vtx_col[k]; xe = vtx_col[j];
      if (ys < low_row) low_row = ys;
      if (ys > high_row) high_row = ys;
      if (ys == ye) continue;
      if (ys < ye) begin
        e_start[k] = ys; e_end[k] = ye; e_col[k] = xs; dx = xe - xs; dy = ye - ys;
      end else begin
        e_start[k] = ye; e_end[k] = ys; e_col[k] = xe; dx = xs - xe; dy = ys - ye;
      end
      e_left[k] = dx < 0;
      if (dx < 0) dx = -dx;
      e_err[k] = (dx > dy) ? dy - dx : dx - dy;
      e_tdx[k] = dx * 2;
      e_tdy[k] = dy * 2;
      e_state[k] = EsWaiting;
    end
    vtx_cnt = 0;
    cur_row = low_row;
    filling = 1'b1;
  endfunction

  function automatic void step_edge(int k);
    int stp, x, f;
    stp = e_left[k] ? -1 : 1;
    x = e_col[k];
    f = e_err[k];
    if (e_tdx[k] > e_tdy[k]) begin
      while (f < 0 && e_tdy[k] > 0) begin
        x += stp;
        f += e_tdy[k];
      end
      f -= e_tdx[k];
    end else begin
      if (f >= 0) begin
        x += stp;
        f -= e_tdy[k];
      end
      f += e_tdx[k];
    end
    e_col[k] = wrap_col(x);
    e_err[k] = f;
  endfunction

  // updates the predictor with one accepted item, queues the spans it gives
  function automatic void predict_spans(bit op, int x, int y, bit lastv);
    int    cols[MaxVertices];
    int    nact, j, a, b, r;
    span_t res[$];
    span_t s;
    if (!op) begin
      if (filling) begin
        filling = 1'b0;
        for (int k = 0; k < MaxVertices; k++) e_state[k] = EsUnused;
        vtx_cnt = 0;
      end
      if (vtx_cnt < MaxVertices) begin
        vtx_col[vtx_cnt] = x;
        vtx_row[vtx_cnt] = y;
        vtx_cnt++;
      end
      if (lastv) close_poly();
      return;
    end
    if (!filling) begin
      s = '{row: '0, first_col: '0, last_col: '0, has_span: 0, row_last: 1, poly_done: 1};
      span_q.push_back(s);
      return;
    end
    r = cur_row;
    nact = 0;
    for (int k = 0; k < MaxVertices; k++) begin
      if (e_state[k] == EsWaiting && e_start[k] == r) e_state[k] = EsActive;
      if (e_state[k] == EsActive && e_end[k] == r) e_state[k] = EsFinished;
      if (e_state[k] == EsActive) begin
        j = nact;
        while (j > 0 && cols[j-1] > e_col[k]) begin
          cols[j] = cols[j-1];
          j--;
        end
        cols[j] = e_col[k];
        nact++;
      end
    end
    for (int p = 0; p + 1 < nact && res.size() < MaxResults; p += 2) begin
      a = cols[p];
      b = cols[p+1];
      if (clip_en) begin
        if (r < clip_t || r >= clip_t + clip_h) continue;
        if (a < clip_l) a = clip_l;
        if (b > clip_l + clip_w - 1) b = clip_l + clip_w - 1;
      end
      if (a > b) continue;
      s = '{row: r[CoordBits-1:0], first_col: a[CoordBits-1:0], last_col: b[CoordBits-1:0],
            has_span: 1, row_last: 0, poly_done: 0};
      res.push_back(s);
    end
    if (res.size() == 0) begin
      s = '{row: r[CoordBits-1:0], first_col: '0, last_col: '0,
            has_span: 0, row_last: 0, poly_done: 0};
      res.push_back(s);
    end
    res[res.size()-1].row_last = 1;
    res[res.size()-1].poly_done = (r >= high_row);
    foreach (res[i]) span_q.push_back(res[i]);
    for (int k = 0; k < MaxVertices; k++)
      if (e_state[k] == EsActive) step_edge(k);
    if (r >= high_row) begin
      filling = 1'b0;
      for (int k = 0; k < MaxVertices; k++) e_state[k] = EsUnused;
      vtx_cnt = 0;
    end else begin
      cur_row = r + 1;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the item is accepted
  task automatic send_item(bit op, int x, int y, bit lastv, bit typed, span_t exp);
    int before_n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    op_in <= op;
    vx_in <= x[CoordBits-1:0];
    vy_in <= y[CoordBits-1:0];
    last_in <= lastv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    before_n = span_q.size();
    predict_spans(op, x, y, lastv);
    if (typed) begin
      while (span_q.size() > before_n) void'(span_q.pop_back());
      span_q.push_back(exp);
    end
    n_items++;
    if (op) n_rows++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (span_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // called at a falling edge, returns at the next falling edge with valid still up
  task automatic cfg_write(logic [CfgIdxBits-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CoordBits-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgClipEnable: clip_en = value[0];
      CfgClipLeft:   clip_l = wrap_col(value);
      CfgClipTop:    clip_t = wrap_col(value);
      CfgClipWidth:  clip_w = value & 32'hfff;
      CfgClipHeight: clip_h = value & 32'hfff;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic set_clip(bit en, int l, int t, int w, int h);
    wait_idle();
    cfg_write(CfgClipEnable, en);
    cfg_write(CfgClipLeft, l);
    cfg_write(CfgClipTop, t);
    cfg_write(CfgClipWidth, w);
    cfg_write(CfgClipHeight, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_step(bit op, int x, int y, bit lastv);
    step_t st;
    st = '{op: op, x: x, y: y, lastv: lastv, typed: 0, exp: '{default: 0}};
    plan.push_back(st);
  endtask

  task automatic add_typed(int r);
    step_t st;
    st = '{op: 1, x: 0, y: 0, lastv: 0, typed: 1,
           exp: '{row: r[CoordBits-1:0], first_col: '0, last_col: '0,
                  has_span: 0, row_last: 1, poly_done: 1}};
    plan.push_back(st);
  endtask

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // one polygon near (cx, cy), then row steps until it ends or is abandoned
  task automatic random_polygon(int cx, int cy);
    int nv, bx, by, sx, sy, x, y, pick;
    bit wide;
    span_t none;
    none = '{default: 0};
    pick = $urandom_range(0, 9);
    nv = (pick == 0) ? $urandom_range(1, 2) :
         (pick == 1) ? $urandom_range(17, 20) : $urandom_range(3, 16);
    wide = (nv <= 4) && ($urandom_range(0, 14) == 0);
    sx = wide ? 4095 : $urandom_range(1, 64);
    sy = $urandom_range(1, 16);
    bx = clamp(cx - 30 + $urandom_range(0, 60), -2048, 2047 - sx);
    by = clamp(cy - 10 + $urandom_range(0, 20), -2048, 2047 - sy);
    if ($urandom_range(0, 7) == 0) send_item(1, 0, 0, 0, 0, none);
    for (int i = 0; i < nv; i++) begin
      x = bx + $urandom_range(0, sx);
      y = by + $urandom_range(0, sy);
      send_item(0, x, y, i == nv - 1, 0, none);
    end
    n_polys++;
    while (filling) begin
      if ($urandom_range(0, 39) == 0) break;
      send_item(1, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                $urandom_range(0, 1), 0, none);
    end
  endtask

  // output side: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  always @(posedge clk) begin
    span_t e;
    if (out_valid && out_ready) begin
      if (span_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t unexpected span: row %0d cols %0d..%0d valid %0b",
                   $time, row_out, start_out, end_out, sv_out);
      end else begin
        e = span_q.pop_front();
        n_spans++;
        if (e.row !== row_out || e.first_col !== start_out || e.last_col !== end_out ||
            e.has_span !== sv_out || e.row_last !== lor_out || e.poly_done !== done_out) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t mismatch: exp row %0d %0d..%0d v%0b l%0b d%0b, got row %0d %0d..%0d v%0b l%0b d%0b",
                     $time, e.row, e.first_col, e.last_col, e.has_span, e.row_last,
                     e.poly_done, row_out, start_out, end_out, sv_out, lor_out, done_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout with %0d spans outstanding", span_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int cx, cy, waited;
    for (int k = 0; k < MaxVertices; k++) e_state[k] = EsUnused;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    add_typed(0);
    add_step(0, 0, 0, 0); add_step(0, 3, 0, 0); add_step(0, 3, 3, 0); add_step(0, 0, 3, 1);
    repeat (4) add_step(1, 0, 0, 0);
    add_step(0, 5, 7, 1); add_typed(7);
    add_step(0, -2048, -2048, 0); add_step(0, 2047, -2047, 0);
    add_step(0, -2048, -2046, 1);
    repeat (3) add_step(1, 0, 0, 0);
    add_step(0, 0, 2045, 0); add_step(0, 1, 2047, 0); add_step(0, -1, 2047, 1);
    add_step(1, 0, 0, 0);
    add_step(0, 0, 0, 1); add_typed(0);
    foreach (plan[i])
      send_item(plan[i].op, plan[i].x, plan[i].y, plan[i].lastv, plan[i].typed, plan[i].exp);

    // random polygons, one clip setting per phase
    for (int ph = 0; ph < 12 && n_items < 480; ph++) begin
      cx = $urandom_range(0, 4095) - 2048;
      cy = $urandom_range(0, 4095) - 2048;
      case (ph)
        0: ;
        1: set_clip(1, -2048, -2048, 4095, 4095);
        2: set_clip(1, cx - 10, cy - 5, 0, 30);
        3: set_clip(1, cx - 10, cy - 5, 40, 0);
        4: begin
          cx = 2030; cy = 2040;
          set_clip(1, 2047, 2047, 4095, 4095);
        end
        5: set_clip(0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
        default: set_clip(1, cx - 20 + $urandom_range(0, 40), cy - 8 + $urandom_range(0, 16),
                          $urandom_range(0, 60), $urandom_range(0, 20));
      endcase
      if (ph == 1) stall_req = 1'b1;
      for (int p = 0; p < 4 && n_items < 480; p++) begin
        quiet = n_items >= 400;
        random_polygon(cx, cy);
      end
    end
    quiet = 1'b1;
    in_valid <= 1'b0;

    waited = 0;
    while (span_q.size() != 0 && waited < StallLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (span_q.size() != 0) n_fail++;
    $display("%0d items (%0d row steps, %0d polygons), %0d spans checked, %0d config writes",
             n_items, n_rows, n_polys, n_spans, n_cfg);
    $display("%0d failures, %0d spans still outstanding", n_fail, span_q.size());
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pgsf_pkg.sv
hdl/pgsf_ctrl.sv
hdl/pgsf_datapath.sv
hdl/polygon_scanline_span_fill_unit.sv
tb/tb.sv
